[src/lsch_pkg.sv]
// Lottery scheduler package: item kinds, status codes, FSM states, walk token.
// Depends on nothing; imported by every other file of the block.
package lsch_pkg;

  localparam int ID_W    = 16;
  localparam int TIX_W   = 16;
  localparam int TOTAL_W = 20;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD      = 2'd0,
    KIND_REASSIGN = 2'd1,
    KIND_SELECT   = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_NONE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  // Token that travels down the cell chain during a walk
  typedef struct packed {
    logic            valid;
    logic            found;
    logic [ID_W-1:0] winner;
  } lsch_tok_t;

endpackage

[src/lsch_if.sv]
// Valid/ready channel interfaces for the lottery scheduler input and result.
// Depends on lsch_pkg for field widths.
interface lsch_in_if
  import lsch_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [ID_W-1:0]    proc_id;
  logic [TIX_W-1:0]   ticket_count;
  logic [TOTAL_W-1:0] draw;

  modport source (output valid, kind, proc_id, ticket_count, draw, input ready);
  modport sink   (input valid, kind, proc_id, ticket_count, draw, output ready);
endinterface

interface lsch_out_if
  import lsch_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [ID_W-1:0]    winner_id;
  logic [TOTAL_W-1:0] tix_total;

  modport source (output valid, status, winner_id, tix_total, input ready);
  modport sink   (input valid, status, winner_id, tix_total, output ready);
endinterface

[src/lsch_cell.sv]
// One table entry of the lottery scheduler: holds an ID and a ticket count,
// adds its tickets to the passing running sum. Depends on lsch_pkg.
module lsch_cell
  import lsch_pkg::*;
#(
  parameter int CNT_W = 5,
  parameter int SUM_W = 25,
  parameter int IDX   = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CNT_W-1:0]   count_i,
  input  logic               wr_en_i,
  input  logic [ID_W-1:0]    wr_id_i,
  input  logic [TIX_W-1:0]   wr_tix_i,
  input  logic               reassign_i,
  input  logic [TOTAL_W-1:0] draw_i,
  input  lsch_tok_t          tok_i,
  input  logic [SUM_W-1:0]   run_i,
  output lsch_tok_t          tok_o,
  output logic [SUM_W-1:0]   run_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  logic [ID_W-1:0]  id_q;
  logic [TIX_W-1:0] tix_q, tix_d;
  lsch_tok_t        tok_q, tok_d;
  logic [SUM_W-1:0] run_q, run_d;
  logic             live;
  logic [SUM_W-1:0] run_sum;

  assign live = tok_i.valid && (MyIdx < count_i);

  // Running sum with this entry's contribution
  always_comb begin
    if (reassign_i) begin
      run_sum = run_i + SUM_W'(id_q);
    end else begin
      run_sum = run_i + SUM_W'(tix_q);
    end
  end

  // Token update
  always_comb begin
    tok_d = tok_i;
    run_d = run_i;
    tix_d = tix_q;
    if (live) begin
      if (reassign_i) begin
        tix_d = id_q;
        run_d = run_sum;
      end else if (!tok_i.found) begin
        run_d = run_sum;
        if (run_sum > SUM_W'(draw_i)) begin
          tok_d.found  = 1'b1;
          tok_d.winner = id_q;
        end
      end
    end
  end

  // Entry storage: written by add, or rewritten as the reassign token passes
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (count_i == MyIdx)) begin
      id_q  <= wr_id_i;
      tix_q <= wr_tix_i;
    end else begin
      tix_q <= tix_d;
    end
    run_q <= run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
  assign run_o = run_q;

endmodule

[src/lottery_scheduler.sv]
// Lottery scheduler top level: controller plus a chain of table cells.
// Depends on lsch_pkg, lsch_in_if/lsch_out_if and lsch_cell.
//
// Usage:
//   in_i carries items (kind, proc_id, ticket_count, draw); out_o returns one
//   result (status, winner_id, tix_total) per item, in order.
//   One item is in work at a time; in_i.ready is high while the controller is
//   idle, also while an earlier result still waits in the output register.
//   Add, unused kind and a select that is rejected up front (zero total or
//   draw at or above the total) skip the walk and are loaded into the output
//   register once it is free. Reassign and a select that walks pass through the
//   walk state: the token is launched in the cycle after acceptance and then
//   steps through one cell per cycle, each cell adding its tickets. The next
//   item can be accepted as soon as a result is registered.
//   When the receiver stalls, the result holds in the output register; one
//   more item can finish its work and then waits until the register frees.
//   Reset empties the table and clears the total; entry contents stay
//   unknown until written, and only entries below the count are ever read.
//   The reported total saturates at 1048575; the walk uses exact sums.
module lottery_scheduler
  import lsch_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  lsch_in_if.sink    in_i,
  lsch_out_if.source out_o
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W = TOTAL_W + CNT_W;
  localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_ENTRIES);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q;
  logic [SUM_W-1:0]   exact_q;
  logic               reassign_q;
  logic [TOTAL_W-1:0] draw_q;
  lsch_tok_t          launch_q;
  status_e            pend_status_q;
  logic [ID_W-1:0]    pend_winner_q;
  logic               out_valid_q;
  status_e            out_status_q;
  logic [ID_W-1:0]    out_winner_q;
  logic [TOTAL_W-1:0] out_total_q;

  logic               accept;
  logic               load_out;
  logic               out_free;
  logic               walk_done;
  logic               select_reject;
  logic               needs_walk;
  logic               wr_en;
  logic [TOTAL_W-1:0] total_sat;
  kind_e              kind;

  lsch_tok_t          tok_w [MAX_ENTRIES+1];
  logic [SUM_W-1:0]   run_w [MAX_ENTRIES+1];

  assign kind      = kind_e'(in_i.kind);
  assign total_sat = (exact_q > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : exact_q[TOTAL_W-1:0];
  assign select_reject = (total_sat == '0) || (in_i.draw >= total_sat);
  assign needs_walk = (kind == KIND_REASSIGN) || ((kind == KIND_SELECT) && !select_reject);
  assign out_free  = !out_valid_q || out_o.ready;
  assign walk_done = tok_w[MAX_ENTRIES].valid;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = needs_walk ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        if (walk_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_i.ready = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_WALK: ;
      ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  assign accept = in_i.valid && in_i.ready;
  assign wr_en  = accept && (kind == KIND_ADD) && (count_q != CntMax);

  // Head of the chain: token launched once draw and mode are registered
  assign tok_w[0] = launch_q;
  assign run_w[0] = '0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    lsch_cell #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W),
      .IDX   (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .count_i    (count_q),
      .wr_en_i    (wr_en),
      .wr_id_i    (in_i.proc_id),
      .wr_tix_i   (in_i.ticket_count),
      .reassign_i (reassign_q),
      .draw_i     (draw_q),
      .tok_i      (tok_w[g]),
      .run_i      (run_w[g]),
      .tok_o      (tok_w[g+1]),
      .run_o      (run_w[g+1])
    );
  end

  // Control registers: state, count, exact total, output valid, reassign flag, launch token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      exact_q     <= '0;
      out_valid_q <= 1'b0;
      reassign_q  <= 1'b0;
      launch_q    <= '0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        count_q <= count_q + CNT_W'(1);
        exact_q <= exact_q + SUM_W'(in_i.ticket_count);
      end
      if (walk_done && reassign_q) begin
        exact_q <= run_w[MAX_ENTRIES];
      end
      if (accept) begin
        reassign_q <= (kind == KIND_REASSIGN);
      end
      launch_q <= '{valid: accept && needs_walk, found: 1'b0, winner: '0};
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Draw, pending result and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      draw_q        <= in_i.draw;
      pend_winner_q <= '0;
      pend_status_q <= STATUS_OK;
      case (kind)
        KIND_ADD:      if (count_q == CntMax) pend_status_q <= STATUS_FULL;
        KIND_SELECT:   if (select_reject) pend_status_q <= STATUS_NONE;
        KIND_REASSIGN: ;
        KIND_UNUSED:   ;
        default:       ;
      endcase
    end
    if (walk_done) begin
      if (reassign_q || tok_w[MAX_ENTRIES].found) begin
        pend_status_q <= STATUS_OK;
      end else begin
        pend_status_q <= STATUS_NONE;
      end
      pend_winner_q <= (!reassign_q && tok_w[MAX_ENTRIES].found) ?
                       tok_w[MAX_ENTRIES].winner : '0;
    end
    if (load_out) begin
      out_status_q <= pend_status_q;
      out_winner_q <= pend_winner_q;
      out_total_q  <= total_sat;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.winner_id = out_winner_q;
  assign out_o.tix_total = out_total_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("entry count beyond table size");

  a_token_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_done |-> (state_q == ST_WALK))
    else $error("walk token arrived outside a walk");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("controller stayed idle after accepting a transaction");

  a_empty_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((count_q == '0) && (state_q == ST_IDLE)) |-> (exact_q == '0))
    else $error("nonzero total with an empty table");

endmodule
